FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gdd_pkg.sv
`default_nettype none

package gdd_pkg;

  // Field and intermediate widths.
  localparam int FIELD_W  = 27;  // packed YYYYMMDD
  localparam int YEAR_W   = 14;  // year, up to 13421 for any 27-bit input
  localparam int REM_W    = 14;  // MMDD part, below 10000
  localparam int Q100_W   = 8;   // year / 100
  localparam int MD_W     = 7;   // month or day, 0 to 99
  localparam int C400_W   = 6;   // ceil(year / 400)
  localparam int FULL_W   = 4;   // full months before the date, 0 to 12
  localparam int CUM_W    = 9;   // days before a month
  localparam int NUM_W    = 23;  // day number from the start of year 0
  localparam int CNT_W    = 23;  // signed day count
  localparam int NSTG     = 5;   // pipeline stages, the last is the output register

  // Exact reciprocal division: floor(x / d) = (x * RCP) >> SH over the input range.
  localparam int RCP10K_W = 28;
  localparam int SH_10K   = 41;
  localparam logic [RCP10K_W-1:0] RCP_10K = 28'd219902326;
  localparam int RCP100_W = 15;
  localparam int SH_100   = 21;
  localparam logic [RCP100_W-1:0] RCP_100 = 15'd20972;

  localparam int DIV_YEAR  = 10000;
  localparam int DIV_CENT  = 100;
  localparam int DAYS_YEAR = 365;
  localparam int MONTHS    = 12;
  localparam int FEB_DONE  = 2;   // full months at which a leap day is already counted

  // Per-stage load enables and valid bits.
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } gdd_ctl_t;

  // Days of a common year before the given number of full months.
  function automatic logic [CUM_W-1:0] cum_days(input logic [FULL_W-1:0] full);
    logic [CUM_W-1:0] days;
    case (full)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      default: days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gdd_ctrl.sv
`default_nettype none

// Valid bits and load enables of the pipeline. A stage loads when it is empty
// or when the stage after it loads, so bubbles close up under a stall.
module gdd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             out_stall,
  output gdd_pkg::gdd_ctl_t     ctl,
  output logic                  in_stall,
  output logic                  out_valid
);

  localparam int NS = gdd_pkg::NSTG;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en    = en;
  assign ctl.vld   = vld_r;
  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

endmodule

`default_nettype wire

FILE: sv/gdd_day_num.sv
`default_nettype none

// Packed YYYYMMDD to day number from the start of year 0, in four stages:
// year split, MMDD remainder and year/100, century terms and month split,
// then the final sum.
module gdd_day_num (
  input  wire logic                        clk,
  input  wire gdd_pkg::gdd_ctl_t           ctl,
  input  wire logic [gdd_pkg::FIELD_W-1:0] in_date,
  output logic [gdd_pkg::NUM_W-1:0]        day_num
);

  localparam int FW   = gdd_pkg::FIELD_W;
  localparam int YW   = gdd_pkg::YEAR_W;
  localparam int RMW  = gdd_pkg::REM_W;
  localparam int QW   = gdd_pkg::Q100_W;
  localparam int MDW  = gdd_pkg::MD_W;
  localparam int C4W  = gdd_pkg::C400_W;
  localparam int FLW  = gdd_pkg::FULL_W;
  localparam int NW   = gdd_pkg::NUM_W;
  localparam int P1W  = FW + gdd_pkg::RCP10K_W;
  localparam int P2W  = YW + gdd_pkg::RCP100_W;
  localparam int P3W  = RMW + gdd_pkg::RCP100_W;

  // Stage 1: year = date / 10000.
  logic [P1W-1:0] p1;
  logic [YW-1:0]  s1_y_r;
  logic [FW-1:0]  s1_v_r;

  assign p1 = P1W'(in_date) * P1W'(gdd_pkg::RCP_10K);

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_y_r <= p1[gdd_pkg::SH_10K +: YW];
      s1_v_r <= in_date;
    end
  end

  // Stage 2: MMDD remainder and year / 100.
  logic [FW-1:0]  rem_full;
  logic [P2W-1:0] p2;
  logic [YW-1:0]  s2_y_r;
  logic [RMW-1:0] s2_rem_r;
  logic [QW-1:0]  s2_q100_r;

  assign rem_full = s1_v_r - FW'(s1_y_r) * FW'(gdd_pkg::DIV_YEAR);
  assign p2       = P2W'(s1_y_r) * P2W'(gdd_pkg::RCP_100);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_y_r    <= s1_y_r;
      s2_rem_r  <= rem_full[RMW-1:0];
      s2_q100_r <= p2[gdd_pkg::SH_100 +: QW];
    end
  end

  // Stage 3: ceil(y/100), ceil(y/400), leap flag, month = MMDD / 100.
  logic [YW-1:0]  r100;
  logic           r100_nz;
  logic [QW-1:0]  c100;
  logic [QW-1:0]  c100_p3;
  logic           leap;
  logic [P3W-1:0] p3;
  logic [YW-1:0]  s3_y_r;
  logic [RMW-1:0] s3_rem_r;
  logic [MDW-1:0] s3_mq_r;
  logic [QW-1:0]  s3_c100_r;
  logic [C4W-1:0] s3_c400_r;
  logic           s3_leap_r;

  assign r100    = s2_y_r - YW'(s2_q100_r) * YW'(gdd_pkg::DIV_CENT);
  assign r100_nz = |r100;
  assign c100    = s2_q100_r + QW'(r100_nz);
  // ceil(y/400) is ceil(ceil(y/100) / 4).
  assign c100_p3 = c100 + QW'(3);
  assign leap    = (s2_y_r[1:0] == 2'b00) && (r100_nz || (s2_q100_r[1:0] == 2'b00));
  assign p3      = P3W'(s2_rem_r) * P3W'(gdd_pkg::RCP_100);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_y_r    <= s2_y_r;
      s3_rem_r  <= s2_rem_r;
      s3_mq_r   <= p3[gdd_pkg::SH_100 +: MDW];
      s3_c100_r <= c100;
      s3_c400_r <= c100_p3[2 +: C4W];
      s3_leap_r <= leap;
    end
  end

  // Stage 4: day, full months and the sum.
  logic [RMW-1:0] dd_full;
  logic [MDW-1:0] day;
  logic [FLW-1:0] full;
  logic [YW-1:0]  y_p3;
  logic           leap_adj;
  logic [NW-1:0]  num;
  logic [NW-1:0]  s4_num_r;

  assign dd_full = s3_rem_r - RMW'(s3_mq_r) * RMW'(gdd_pkg::DIV_CENT);
  assign day     = dd_full[MDW-1:0];
  assign y_p3    = s3_y_r + YW'(3);

  always_comb begin
    if (s3_mq_r == '0) begin
      full = '0;
    end else if (s3_mq_r > MDW'(gdd_pkg::MONTHS)) begin
      full = FLW'(gdd_pkg::MONTHS);
    end else begin
      full = FLW'(s3_mq_r - MDW'(1));
    end
  end

  assign leap_adj = s3_leap_r && (full >= FLW'(gdd_pkg::FEB_DONE));

  assign num = NW'(s3_y_r) * NW'(gdd_pkg::DAYS_YEAR) + NW'(y_p3[YW-1:2])
             - NW'(s3_c100_r) + NW'(s3_c400_r)
             + NW'(gdd_pkg::cum_days(full)) + NW'(leap_adj) + NW'(day);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_num_r <= num;
    end
  end

  assign day_num = s4_num_r;

endmodule

`default_nettype wire

FILE: sv/gregorian_date_difference_top.sv
`default_nettype none

// Inclusive day count between two Gregorian dates.
// Input channel: in_start_date and in_end_date, each packed decimal YYYYMMDD,
// with in_valid / in_stall. A beat is taken on a rising edge with in_valid
// high and in_stall low.
// Result channel: out_day_count, a 23-bit two's complement count equal to
// day(end) - day(start) + 1, with out_valid / out_stall. The count is
// negative or zero when the end date precedes the start date and saturates
// at the 23-bit limits, which only malformed dates can reach.
// The pipeline takes one beat per cycle unless the receiver stalls. Its
// depth is set by the reciprocal multiplications for the year (/10000),
// for the century (year / 100) and for the month (MMDD / 100), and by the
// final sum, each in a stage of its own, plus the subtract-and-saturate
// output register.
// Reset clears every valid bit; data registers are not reset.
// When the receiver stalls, the result holds and stages behind it keep
// loading until they are full, so empty slots close up before in_stall rises.
module gregorian_date_difference_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gdd_pkg::FIELD_W-1:0] in_start_date,
  input  wire logic [gdd_pkg::FIELD_W-1:0] in_end_date,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [gdd_pkg::CNT_W-1:0] out_day_count
);

  localparam int NS = gdd_pkg::NSTG;
  localparam int NW = gdd_pkg::NUM_W;
  localparam int CW = gdd_pkg::CNT_W;
  // Difference width: two extra bits hold the full range of end - start + 1.
  localparam int DW = NW + 2;
  localparam logic signed [DW-1:0] SAT_HI = DW'((1 <<< (CW - 1)) - 1);
  localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);

  gdd_pkg::gdd_ctl_t ctl;
  logic [NW-1:0]     start_num;
  logic [NW-1:0]     end_num;

  gdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Both dates run through identical stages in lockstep.
  gdd_day_num u_start (
    .clk     (clk),
    .ctl     (ctl),
    .in_date (in_start_date),
    .day_num (start_num)
  );

  gdd_day_num u_end (
    .clk     (clk),
    .ctl     (ctl),
    .in_date (in_end_date),
    .day_num (end_num)
  );

  // Output stage: subtract, count both ends, clamp to the result width.
  logic signed [DW-1:0] diff;
  logic signed [CW-1:0] day_count_nxt;
  logic signed [CW-1:0] day_count_r;

  assign diff = $signed({2'b00, end_num}) - $signed({2'b00, start_num}) + DW'(1);

  always_comb begin
    if (diff > SAT_HI) begin
      day_count_nxt = SAT_HI[CW-1:0];
    end else if (diff < SAT_LO) begin
      day_count_nxt = SAT_LO[CW-1:0];
    end else begin
      day_count_nxt = diff[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[NS-1]) begin
      day_count_r <= day_count_nxt;
    end
  end

  assign out_day_count = day_count_r;

`include "assert_macros.svh"

  // The input is only held off when every stage holds a live beat.
  `GDD_ASSERT_NOW(a_stall_full, in_stall, (&ctl.vld), "input stalled with a free stage")
  // Holding off the input needs a result that the receiver refuses.
  `GDD_ASSERT_NOW(a_stall_cause, in_stall, (out_valid && out_stall), "input stalled without cause")
  // A new result only appears when the last day-number stage had a beat.
  `GDD_ASSERT_NOW(a_rise_src, $rose(out_valid), $past(ctl.vld[NS-2]), "result from empty stage")

endmodule

`default_nettype wire

FILE: bench/tb_gregorian_date_difference_top.sv
`timescale 1ns / 1ps

module tb_gregorian_date_difference_top;

  localparam int FW = gdd_pkg::FIELD_W;
  localparam int CW = gdd_pkg::CNT_W;

  // The signed count saturates at the limits of its 23-bit field.
  localparam longint COUNT_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COUNT_MIN = -(64'sd1 <<< (CW - 1));

  // Days of a common year that lie before a given number of whole months.
  localparam int DAYS_BEFORE_MONTH [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                            304, 334, 365};

  // Cycles allowed to pass once the pipe has drained, before the run is closed.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 1600;

  // The random part runs with no idling on either side for this stretch.
  localparam int QUIET_FIRST = 700;
  localparam int QUIET_LAST  = 1000;
  // Partway through the random part the sender holds off until the pipe is empty.
  localparam int HOLD_AT     = 1200;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FW-1:0]        in_start_date = '0;
  logic [FW-1:0]        in_end_date = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_day_count;

  // Counts that the block still owes us, oldest first.
  logic signed [CW-1:0] pending_counts [$];
  int                   mismatch_count = 0;
  bit                   quiet = 1'b0;

  gregorian_date_difference_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_date (in_start_date),
    .in_end_date   (in_end_date),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_day_count (out_day_count)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Date arithmetic used to predict each count.
  // ---------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap_year(longint yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Day number of a packed YYYYMMDD word, counted from the start of year zero.
  // Malformed months are clamped to "no months" or "all twelve months", and a
  // malformed day is simply added, which is how the block treats them too.
  function automatic longint days_since_year_zero(logic [FW-1:0] date_word);
    longint v;
    longint yr;
    longint mon;
    longint dy;
    longint n;
    int     whole_months;
    v   = longint'(date_word);
    yr  = v / 10000;
    mon = (v / 100) % 100;
    dy  = v % 100;
    n   = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    if (mon < 1) begin
      whole_months = 0;
    end else if (mon > 12) begin
      whole_months = 12;
    end else begin
      whole_months = int'(mon) - 1;
    end
    n += DAYS_BEFORE_MONTH[whole_months];
    // A leap day counts once February is behind us.
    if (whole_months >= 2 && is_leap_year(yr)) begin
      n += 1;
    end
    return n + dy;
  endfunction

  // Inclusive count from the start date to the end date, saturated to 23 bits.
  function automatic logic signed [CW-1:0] expected_day_count(logic [FW-1:0] start_word,
                                                              logic [FW-1:0] stop_word);
    longint r;
    r = days_since_year_zero(stop_word) - days_since_year_zero(start_word) + 1;
    if (r > COUNT_MAX) begin
      r = COUNT_MAX;
    end
    if (r < COUNT_MIN) begin
      r = COUNT_MIN;
    end
    return r[CW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------

  function automatic int month_length(int yr, int mon);
    int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (mon == 2 && is_leap_year(yr)) begin
      return 29;
    end
    return lengths[mon - 1];
  endfunction

  function automatic logic [FW-1:0] pack_date(int yr, int mon, int dy);
    return FW'(yr * 10000 + mon * 100 + dy);
  endfunction

  // Year picker that leans on the interesting ones: centuries, the very
  // first years and the very last ones.
  function automatic int pick_year();
    case ($urandom_range(0, 9))
      0:       return 100 * $urandom_range(1, 99);
      1:       return 400 * $urandom_range(1, 24);
      2:       return $urandom_range(1, 20);
      3:       return $urandom_range(9980, 9999);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic logic [FW-1:0] valid_date_in(int yr);
    int mon;
    mon = $urandom_range(1, 12);
    return pack_date(yr, mon, $urandom_range(1, month_length(yr, mon)));
  endfunction

  // One of the last days of February or the first days of March, where the leap
  // rule decides the count.
  function automatic logic [FW-1:0] leap_edge_date(int yr);
    case ($urandom_range(0, 2))
      0:       return pack_date(yr, 2, 28);
      1:       return is_leap_year(yr) ? pack_date(yr, 2, 29) : pack_date(yr, 3, 1);
      default: return pack_date(yr, 3, $urandom_range(1, 2));
    endcase
  endfunction

  // Fields outside the calendar: year zero or past 9999, month zero or above
  // twelve, day zero or past the end of the month, or no structure at all.
  function automatic logic [FW-1:0] malformed_date();
    case ($urandom_range(0, 3))
      0:       return FW'($urandom);
      1:       return pack_date($urandom_range(0, 13421), $urandom_range(0, 99),
                                $urandom_range(0, 99));
      2:       return pack_date($urandom_range(0, 9999), $urandom_range(0, 1) ? 0 : 13,
                                $urandom_range(1, 28));
      default: return pack_date($urandom_range(0, 9999), $urandom_range(1, 12),
                                $urandom_range(0, 1) ? 0 : $urandom_range(32, 99));
    endcase
  endfunction

  // Mostly well-formed date pairs, many of them close together so that the
  // month and leap-day terms matter, plus a share of malformed words.
  task automatic pick_random_pair(output logic [FW-1:0] start_word,
                                  output logic [FW-1:0] stop_word);
    int yr;
    int pick;
    pick = $urandom_range(0, 99);
    yr   = pick_year();
    if (pick < 40) begin
      start_word = valid_date_in(yr);
      stop_word  = valid_date_in(pick_year());
    end else if (pick < 62) begin
      start_word = valid_date_in(yr);
      yr         = yr + $urandom_range(0, 2) - 1;
      stop_word  = valid_date_in((yr < 1) ? 1 : (yr > 9999) ? 9999 : yr);
    end else if (pick < 82) begin
      start_word = leap_edge_date(yr);
      stop_word  = leap_edge_date(($urandom_range(0, 1) && yr < 9999) ? yr + 1 : yr);
      if ($urandom_range(0, 3) == 0) begin
        {start_word, stop_word} = {stop_word, start_word};
      end
    end else begin
      start_word = ($urandom_range(0, 2) == 0) ? valid_date_in(yr) : malformed_date();
      stop_word  = malformed_date();
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed table. A count is typed in only where it is plain to see;
  // the other rows are checked against the predictor.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [FW-1:0]        start_word;
    logic [FW-1:0]        stop_word;
    logic                 typed;
    logic signed [CW-1:0] count;
  } date_row_t;

  localparam int DIRECTED_ROWS = 20;

  localparam date_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Same date gives one day, even on a leap day.
    '{27'd20240229, 27'd20240229, 1'b1, 23'sd1},
    // Full calendar range, both directions.
    '{27'd10101,    27'd99991231, 1'b1, 23'sd3652059},
    '{27'd99991231, 27'd10101,    1'b1, -23'sd3652057},
    // All-zero against all-ones words saturate at both limits; then zero and alternating-bit words.
    '{27'd0,        27'h7FFFFFF,  1'b1, 23'sd4194303},
    '{27'h7FFFFFF,  27'd0,        1'b1, -23'sd4194304},
    '{27'd0,        27'd0,        1'b1, 23'sd1},
    '{27'h5555555,  27'h2AAAAAA,  1'b0, '0},
    // Leap February, a century that is not leap, and one that is.
    '{27'd20240228, 27'd20240301, 1'b0, '0},
    '{27'd19000228, 27'd19000301, 1'b0, '0},
    '{27'd20000228, 27'd20000301, 1'b0, '0},
    '{27'd19991231, 27'd20000101, 1'b1, 23'sd2},
    // Year zero is a leap year under the rule.
    '{27'd101,      27'd1231,     1'b0, '0},
    // Month zero adds no months; a month above twelve adds all of them.
    '{27'd20230015, 27'd20230115, 1'b0, '0},
    '{27'd20231305, 27'd20239905, 1'b0, '0},
    // Day zero and a day far past the month end are added as they stand.
    '{27'd20230100, 27'd20230199, 1'b0, '0},
    '{27'd20240200, 27'd20240299, 1'b0, '0},
    // Years beyond 9999.
    '{27'd120000101, 27'd120001231, 1'b0, '0},
    '{27'd99991231, 27'd134211231, 1'b0, '0},
    // End before start gives zero or a negative count.
    '{27'd20231231, 27'd20230101, 1'b0, '0},
    '{27'd20230102, 27'd20230101, 1'b1, 23'sd0}
  };

  // ---------------------------------------------------------------------
  // Input side. Every assignment happens at a rising edge, and in_valid is
  // dropped only in steps where it is not also raised.
  // ---------------------------------------------------------------------

  // Offer one beat and hold it until the block takes it, then record what
  // the block owes us for it.
  task automatic send_pair(logic [FW-1:0] start_word, logic [FW-1:0] stop_word,
                           logic signed [CW-1:0] owed);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_start_date <= start_word;
    in_end_date   <= stop_word;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_counts.push_back(owed);
  endtask

  // Stop sending until every owed count has come back, or the limit runs out.
  task automatic hold_until_drained();
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_counts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    logic [FW-1:0]        start_word;
    logic [FW-1:0]        stop_word;
    logic signed [CW-1:0] owed;
    // Reset is held low from the start and released once.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      owed = DIRECTED[i].typed ? DIRECTED[i].count
                               : expected_day_count(DIRECTED[i].start_word,
                                                    DIRECTED[i].stop_word);
      send_pair(DIRECTED[i].start_word, DIRECTED[i].stop_word, owed);
    end
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
      if (i == HOLD_AT) begin
        hold_until_drained();
      end
      pick_random_pair(start_word, stop_word);
      send_pair(start_word, stop_word, expected_day_count(start_word, stop_word));
    end
    quiet = 1'b0;

    // Let the pipe empty out and give it a few more cycles to show any
    // beat that should not be there.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $error("day_count: %0d expected beats never arrived", pending_counts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_gregorian_date_difference_top: done, clean");
    end else begin
      $display("tb_gregorian_date_difference_top: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random stall, except during the quiet stretch.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  // Each result beat is checked against the oldest owed count. Values are
  // sampled as they stood just before the edge.
  always @(posedge clk) begin
    logic signed [CW-1:0] owed;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $error("day_count: beat with value %0d arrived with nothing expected",
               out_day_count);
        mismatch_count++;
      end else begin
        owed = pending_counts.pop_front();
        if (out_day_count !== owed) begin
          $error("day_count: expected %0d, got %0d", owed, out_day_count);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_gregorian_date_difference_top: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/gdd_pkg.sv
sv/gdd_ctrl.sv
sv/gdd_day_num.sv
sv/gregorian_date_difference_top.sv
bench/tb_gregorian_date_difference_top.sv
